// ----- hdl/hcm_pkg.sv -----
// Shared constants, codes and types of the coset matrix generator.
// Used by hcm_divider, hcm_row_mux and hecke_coset_matrix_generator.
`default_nettype none

package hcm_pkg;

   // Field and port widths.
   localparam int PRIME_BITS_DEFAULT = 8;
   localparam int PRIME_W            = 8;
   localparam int INDEX_W            = 32;
   localparam int ENTRY_W            = 18;
   localparam int ROW_W              = 2;
   localparam int CSR_INDEX_W        = 8;
   localparam int CSR_DATA_W         = 8;
   localparam int REQ_DATA_W         = 32;
   localparam int RSP_DATA_W         = 80;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_PRIME  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FAMILY = 8'd1;

   // Coset shapes for the index ranges of the two families; F1_SMALL covers two ranges.
   localparam int CASE_W = 4;
   localparam logic [CASE_W-1:0] CASE_F0_DIGITS = 4'd0;
   localparam logic [CASE_W-1:0] CASE_F0_DIAG   = 4'd1;
   localparam logic [CASE_W-1:0] CASE_F0_LINE   = 4'd2;
   localparam logic [CASE_W-1:0] CASE_F0_LOWER  = 4'd3;
   localparam logic [CASE_W-1:0] CASE_F1_ZERO   = 4'd4;
   localparam logic [CASE_W-1:0] CASE_F1_SMALL  = 4'd5;
   localparam logic [CASE_W-1:0] CASE_F1_COL    = 4'd6;
   localparam logic [CASE_W-1:0] CASE_F1_MID    = 4'd7;
   localparam logic [CASE_W-1:0] CASE_F1_TOP    = 4'd8;

   typedef logic signed [ENTRY_W-1:0] entry_type;

   // Everything the row builder needs to form one matrix row.
   typedef struct packed {
      logic [CASE_W-1:0] case_code;
      logic [15:0]       fa;
      logic [7:0]        fb;
      logic [15:0]       fc;
      logic [7:0]        p;
      logic [15:0]       p2;
      logic [15:0]       prod_bp;
      logic [23:0]       prod_ap;
      logic [23:0]       prod_ab;
   } fields_type;

   typedef struct packed {
      entry_type col3;
      entry_type col2;
      entry_type col1;
      entry_type col0;
   } row_type;

endpackage

`default_nettype wire

// ----- hdl/hcm_divider.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on hcm_pkg for its default widths.
`default_nettype none

module hcm_divider #(
   parameter int DIVIDEND_W = hcm_pkg::INDEX_W,
   parameter int DIVISOR_W  = hcm_pkg::PRIME_W
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic                       busy,
   output logic                       done,
   output logic [DIVIDEND_W-1:0]      quotient,
   output logic [DIVISOR_W-1:0]       remainder
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  done_ff, done_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIVISOR_W:0]    partial;
   logic                  fits;

   // One restoring step: shift in the next dividend bit and try the divisor.
   always_comb begin
      partial = {rem_ff, quo_ff[DIVIDEND_W-1]};
      fits    = (partial >= {1'b0, dvs_ff});
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         cnt_in = CNT_W'(DIVIDEND_W);
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
         quo_in  = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in  = fits ? DIVISOR_W'(partial - {1'b0, dvs_ff}) : partial[DIVISOR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy      = (cnt_ff != '0);
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ----- hdl/hcm_row_mux.sv -----
// Forms one row of the coset matrix from the case code and computed fields.
// Depends on hcm_pkg for fields_type, row_type and the case codes.
`default_nettype none

module hcm_row_mux (
   input  wire hcm_pkg::fields_type          fields,
   input  wire logic [hcm_pkg::ROW_W-1:0]    row,
   output hcm_pkg::row_type                  row_out
);

   function automatic hcm_pkg::row_type mk(input hcm_pkg::entry_type c0,
                                           input hcm_pkg::entry_type c1,
                                           input hcm_pkg::entry_type c2,
                                           input hcm_pkg::entry_type c3);
      hcm_pkg::row_type r;
      r.col0 = c0;
      r.col1 = c1;
      r.col2 = c2;
      r.col3 = c3;
      return r;
   endfunction

   hcm_pkg::entry_type zv, one, pv, p2v, av, bv, cv, bp, ap, abc;

   // Entry values, all wrapped to the entry width.
   always_comb begin
      zv  = '0;
      one = hcm_pkg::ENTRY_W'(1);
      pv  = hcm_pkg::ENTRY_W'(fields.p);
      p2v = hcm_pkg::ENTRY_W'(fields.p2);
      av  = hcm_pkg::ENTRY_W'(fields.fa);
      bv  = hcm_pkg::ENTRY_W'(fields.fb);
      cv  = hcm_pkg::ENTRY_W'(fields.fc);
      bp  = hcm_pkg::ENTRY_W'(fields.prod_bp);
      ap  = hcm_pkg::ENTRY_W'(fields.prod_ap);
      abc = hcm_pkg::ENTRY_W'(fields.prod_ab + 24'(fields.fc));
   end

   // Row selection per coset shape.
   always_comb begin
      row_out = mk(zv, zv, zv, zv);
      case (fields.case_code)
         hcm_pkg::CASE_F0_DIGITS: begin
            case (row)
               2'd0:    row_out = mk(one, zv, av, bv);
               2'd1:    row_out = mk(zv, one, bv, cv);
               2'd2:    row_out = mk(zv, zv, pv, zv);
               default: row_out = mk(zv, zv, zv, pv);
            endcase
         end
         hcm_pkg::CASE_F0_DIAG: begin
            case (row)
               2'd0:    row_out = mk(pv, zv, zv, zv);
               2'd1:    row_out = mk(zv, pv, zv, zv);
               2'd2:    row_out = mk(zv, zv, one, zv);
               default: row_out = mk(zv, zv, zv, one);
            endcase
         end
         hcm_pkg::CASE_F0_LINE: begin
            case (row)
               2'd0:    row_out = mk(one, zv, av, zv);
               2'd1:    row_out = mk(zv, pv, zv, zv);
               2'd2:    row_out = mk(zv, zv, pv, zv);
               default: row_out = mk(zv, zv, zv, one);
            endcase
         end
         hcm_pkg::CASE_F0_LOWER: begin
            case (row)
               2'd0:    row_out = mk(pv, zv, zv, zv);
               2'd1:    row_out = mk(-av, one, zv, bv);
               2'd2:    row_out = mk(zv, zv, one, av);
               default: row_out = mk(zv, zv, zv, pv);
            endcase
         end
         hcm_pkg::CASE_F1_ZERO: begin
            case (row)
               2'd0:    row_out = mk(pv, zv, zv, zv);
               2'd1:    row_out = mk(zv, p2v, zv, zv);
               2'd2:    row_out = mk(zv, zv, pv, zv);
               default: row_out = mk(zv, zv, zv, one);
            endcase
         end
         hcm_pkg::CASE_F1_SMALL: begin
            case (row)
               2'd0:    row_out = mk(pv, zv, av, bv);
               2'd1:    row_out = mk(zv, pv, bv, cv);
               2'd2:    row_out = mk(zv, zv, pv, zv);
               default: row_out = mk(zv, zv, zv, pv);
            endcase
         end
         hcm_pkg::CASE_F1_COL: begin
            case (row)
               2'd0:    row_out = mk(p2v, zv, zv, zv);
               2'd1:    row_out = mk(-ap, pv, zv, zv);
               2'd2:    row_out = mk(zv, zv, one, av);
               default: row_out = mk(zv, zv, zv, pv);
            endcase
         end
         hcm_pkg::CASE_F1_MID: begin
            case (row)
               2'd0:    row_out = mk(one, zv, av, -bv);
               2'd1:    row_out = mk(zv, pv, -bp, zv);
               2'd2:    row_out = mk(zv, zv, p2v, zv);
               default: row_out = mk(zv, zv, zv, pv);
            endcase
         end
         hcm_pkg::CASE_F1_TOP: begin
            case (row)
               2'd0:    row_out = mk(pv, zv, zv, bp);
               2'd1:    row_out = mk(-av, one, bv, abc);
               2'd2:    row_out = mk(zv, zv, pv, ap);
               default: row_out = mk(zv, zv, zv, p2v);
            endcase
         end
         default: row_out = mk(zv, zv, zv, zv);
      endcase
   end

endmodule

`default_nettype wire

// ----- hdl/hecke_coset_matrix_generator.sv -----
// Coset matrix generator: one index in, four matrix rows out (one row if out of range).
// Digits, residues and the inverse come from divisions on the shared serial divider;
// the inverse case runs Euclid, which needs at most 11 divisions below 256.
// One index at a time, req_tready high only while idle; output stalls hold the emit state.
// Synchronous active-high reset: prime 2, family 0, no result pending. Uses hcm_pkg.
`default_nettype none

module hecke_coset_matrix_generator #(
   parameter int PRIME_BITS = hcm_pkg::PRIME_BITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // coset_index [31:0]
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [hcm_pkg::REQ_DATA_W-1:0]     req_tdata,
   // row_number [1:0], entry_col0 [19:2], entry_col1 [37:20],
   // entry_col2 [55:38], entry_col3 [73:56], zero fill [79:74]
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [hcm_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   // index_out_of_range [0]
   output logic                                    rsp_tuser,
   output logic                                    rsp_tlast,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [hcm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [hcm_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam logic [7:0] PMASK = (PRIME_BITS >= 8) ? 8'hFF : 8'((1 << PRIME_BITS) - 1);

   localparam logic [4:0] ST_IDLE     = 5'd0;
   localparam logic [4:0] ST_P2       = 5'd1;
   localparam logic [4:0] ST_P3       = 5'd2;
   localparam logic [4:0] ST_P4       = 5'd3;
   localparam logic [4:0] ST_SUMS     = 5'd4;
   localparam logic [4:0] ST_CLASSIFY = 5'd5;
   localparam logic [4:0] ST_DIG      = 5'd6;
   localparam logic [4:0] ST_AMOD     = 5'd7;
   localparam logic [4:0] ST_BMOD     = 5'd8;
   localparam logic [4:0] ST_SQ       = 5'd9;
   localparam logic [4:0] ST_SQMOD    = 5'd10;
   localparam logic [4:0] ST_EUC      = 5'd11;
   localparam logic [4:0] ST_INV      = 5'd12;
   localparam logic [4:0] ST_CMUL     = 5'd13;
   localparam logic [4:0] ST_CMOD     = 5'd14;
   localparam logic [4:0] ST_WAIT     = 5'd15;
   localparam logic [4:0] ST_FIELDS   = 5'd16;
   localparam logic [4:0] ST_MUL0     = 5'd17;
   localparam logic [4:0] ST_MUL1     = 5'd18;
   localparam logic [4:0] ST_MUL2     = 5'd19;
   localparam logic [4:0] ST_EMIT     = 5'd20;

   localparam logic [2:0] DK_DIGIT  = 3'd0;
   localparam logic [2:0] DK_AMOD   = 3'd1;
   localparam logic [2:0] DK_BMOD   = 3'd2;
   localparam logic [2:0] DK_SQMOD  = 3'd3;
   localparam logic [2:0] DK_EUCLID = 3'd4;
   localparam logic [2:0] DK_CMOD   = 3'd5;

   // Control and configuration registers.
   logic [4:0]  state_ff, state_in;
   logic [7:0]  prime_ff, prime_in;
   logic        family_ff, family_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // Working registers.
   logic [31:0] k_ff, k_in;
   logic [7:0]  p_ff, p_in;
   logic        fam_ff, fam_in;
   logic [15:0] p2_ff, p2_in;
   logic [23:0] p3_ff, p3_in;
   logic [31:0] p4_ff, p4_in;
   logic [33:0] cnt_ff, cnt_in;
   logic [33:0] base1_ff, base1_in;
   logic [33:0] base2_ff, base2_in;
   logic [hcm_pkg::CASE_W-1:0] case_ff, case_in;
   logic        oor_ff, oor_in;
   logic [31:0] val_ff, val_in;
   logic [7:0]  dig_ff [3], dig_in [3];
   logic [1:0]  dig_idx_ff, dig_idx_in;
   logic [1:0]  ndig_ff, ndig_in;
   logic [15:0] fa_ff, fa_in;
   logic [7:0]  fb_ff, fb_in;
   logic [15:0] fc_ff, fc_in;
   logic [15:0] bp_ff, bp_in;
   logic [23:0] ap_ff, ap_in;
   logic [23:0] ab_ff, ab_in;
   logic [7:0]  x_ff, x_in;
   logic [7:0]  r0_ff, r0_in;
   logic [7:0]  r1_ff, r1_in;
   logic signed [11:0] t0_ff, t0_in;
   logic signed [11:0] t1_ff, t1_in;
   logic [7:0]  inv_ff, inv_in;
   logic [2:0]  kind_ff, kind_in;
   logic [1:0]  row_ff, row_in;
   logic [hcm_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic        rsp_user_ff, rsp_user_in;
   logic        rsp_last_ff, rsp_last_in;

   // Shared multiplier and divider hookup.
   logic [31:0] mul_a;
   logic [7:0]  mul_b;
   logic [39:0] mul_p;
   logic        div_start, div_busy, div_done;
   logic [31:0] div_dividend, div_quot;
   logic [7:0]  div_divisor, div_rem;

   logic [33:0] kx, sub_sel, k_sub;
   logic signed [20:0] euc_prod;
   logic signed [11:0] p_s;
   logic        load_row;

   hcm_pkg::fields_type fields;
   hcm_pkg::row_type    row_val;

   hcm_divider #(
      .DIVIDEND_W (hcm_pkg::INDEX_W),
      .DIVISOR_W  (hcm_pkg::PRIME_W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   always_comb begin
      fields.case_code = case_ff;
      fields.fa        = fa_ff;
      fields.fb        = fb_ff;
      fields.fc        = fc_ff;
      fields.p         = p_ff;
      fields.p2        = p2_ff;
      fields.prod_bp   = bp_ff;
      fields.prod_ap   = ap_ff;
      fields.prod_ab   = ab_ff;
   end

   hcm_row_mux u_row_mux (
      .fields  (fields),
      .row     (row_ff),
      .row_out (row_val)
   );

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = 32'(p_ff);
      mul_b = p_ff;
      case (state_ff)
         ST_P3:   mul_a = 32'(p2_ff);
         ST_P4:   mul_a = 32'(p3_ff);
         ST_SQ:   begin mul_a = 32'(fb_ff); mul_b = fb_ff;  end
         ST_CMUL: begin mul_a = 32'(x_ff);  mul_b = inv_ff; end
         ST_MUL0: mul_a = 32'(fb_ff);
         ST_MUL1: mul_a = 32'(fa_ff);
         ST_MUL2: begin mul_a = 32'(fa_ff); mul_b = fb_ff;  end
         default: mul_a = 32'(p_ff);
      endcase
   end

   assign mul_p = {8'b0, mul_a} * {32'b0, mul_b};

   // Divider operand selection and start strobes.
   always_comb begin
      div_start    = 1'b0;
      div_dividend = val_ff;
      div_divisor  = p_ff;
      case (state_ff)
         ST_DIG, ST_BMOD, ST_SQMOD, ST_CMOD: div_start = 1'b1;
         ST_AMOD: begin
            div_start   = 1'b1;
            div_divisor = p_ff - 8'd1;
         end
         ST_EUC: begin
            div_start    = (r1_ff != 8'd0);
            div_dividend = 32'(r0_ff);
            div_divisor  = r1_ff;
         end
         default: div_start = 1'b0;
      endcase
   end

   // Range classification operands.
   always_comb begin
      kx = {2'b0, k_ff};
      sub_sel = base2_ff;
      if (fam_ff == 1'b0) begin
         if (kx < base2_ff) sub_sel = base1_ff;
      end else begin
         if (kx < 34'(p2_ff))   sub_sel = 34'(p_ff);
         else if (kx < base1_ff) sub_sel = 34'(p2_ff);
         else if (kx < base2_ff) sub_sel = base1_ff;
      end
      k_sub = kx - sub_sel;
   end

   assign euc_prod = $signed({1'b0, div_quot[7:0]}) * t1_ff;
   assign p_s      = $signed({4'b0, p_ff});
   assign load_row = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);

   // Sequencer.
   always_comb begin
      state_in    = state_ff;
      prime_in    = prime_ff;
      family_in   = family_ff;
      k_in        = k_ff;
      p_in        = p_ff;
      fam_in      = fam_ff;
      p2_in       = p2_ff;
      p3_in       = p3_ff;
      p4_in       = p4_ff;
      cnt_in      = cnt_ff;
      base1_in    = base1_ff;
      base2_in    = base2_ff;
      case_in     = case_ff;
      oor_in      = oor_ff;
      val_in      = val_ff;
      dig_in      = dig_ff;
      dig_idx_in  = dig_idx_ff;
      ndig_in     = ndig_ff;
      fa_in       = fa_ff;
      fb_in       = fb_ff;
      fc_in       = fc_ff;
      bp_in       = bp_ff;
      ap_in       = ap_ff;
      ab_in       = ab_ff;
      x_in        = x_ff;
      r0_in       = r0_ff;
      r1_in       = r1_ff;
      t0_in       = t0_ff;
      t1_in       = t1_ff;
      inv_in      = inv_ff;
      kind_in     = kind_ff;
      row_in      = row_ff;

      // Configuration writes.
      if (csr_valid) begin
         if (csr_index == hcm_pkg::REG_PRIME)  prime_in  = csr_data;
         if (csr_index == hcm_pkg::REG_FAMILY) family_in = csr_data[0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               k_in     = req_tdata[31:0];
               p_in     = prime_ff & PMASK;
               fam_in   = family_ff;
               oor_in   = 1'b0;
               row_in   = 2'd0;
               fa_in    = '0;
               fb_in    = '0;
               fc_in    = '0;
               state_in = ST_P2;
            end
         end
         ST_P2: begin
            p2_in    = mul_p[15:0];
            state_in = ST_P3;
         end
         ST_P3: begin
            p3_in    = mul_p[23:0];
            state_in = ST_P4;
         end
         ST_P4: begin
            p4_in    = mul_p[31:0];
            state_in = ST_SUMS;
         end
         ST_SUMS: begin
            if (fam_ff == 1'b0) begin
               cnt_in   = 34'(p3_ff) + 34'(p2_ff) + 34'(p_ff) + 34'd1;
               base1_in = 34'(p3_ff) + 34'd1;
               base2_in = 34'(p3_ff) + 34'(p_ff) + 34'd1;
            end else begin
               cnt_in   = 34'(p4_ff) + 34'(p3_ff) + 34'(p2_ff) + 34'(p_ff);
               base1_in = 34'(p2_ff) + 34'(p_ff);
               base2_in = 34'(p3_ff) + 34'(p2_ff) + 34'(p_ff);
            end
            state_in = ST_CLASSIFY;
         end
         ST_CLASSIFY: begin
            dig_idx_in = 2'd0;
            state_in   = ST_MUL0;
            if (p_ff < 8'd2 || kx >= cnt_ff) begin
               oor_in   = 1'b1;
               state_in = ST_EMIT;
            end else if (fam_ff == 1'b0) begin
               if (kx < 34'(p3_ff)) begin
                  case_in  = hcm_pkg::CASE_F0_DIGITS;
                  val_in   = k_ff;
                  ndig_in  = 2'd3;
                  state_in = ST_DIG;
               end else if (kx < base1_ff) begin
                  case_in  = hcm_pkg::CASE_F0_DIAG;
               end else if (kx < base2_ff) begin
                  case_in  = hcm_pkg::CASE_F0_LINE;
                  fa_in    = k_sub[15:0];
               end else begin
                  case_in  = hcm_pkg::CASE_F0_LOWER;
                  val_in   = k_sub[31:0];
                  ndig_in  = 2'd2;
                  state_in = ST_DIG;
               end
            end else begin
               if (k_ff == 32'd0) begin
                  case_in  = hcm_pkg::CASE_F1_ZERO;
               end else if (kx < 34'(p_ff)) begin
                  // Small index: only the corner entry is set.
                  case_in  = hcm_pkg::CASE_F1_SMALL;
                  fc_in    = k_ff[15:0];
               end else if (kx < 34'(p2_ff)) begin
                  case_in  = hcm_pkg::CASE_F1_SMALL;
                  val_in   = k_sub[31:0];
                  state_in = ST_AMOD;
               end else if (kx < base1_ff) begin
                  case_in  = hcm_pkg::CASE_F1_COL;
                  fa_in    = k_sub[15:0];
               end else if (kx < base2_ff) begin
                  case_in  = hcm_pkg::CASE_F1_MID;
                  val_in   = k_sub[31:0];
                  ndig_in  = 2'd1;
                  state_in = ST_DIG;
               end else begin
                  case_in  = hcm_pkg::CASE_F1_TOP;
                  val_in   = k_sub[31:0];
                  ndig_in  = 2'd2;
                  state_in = ST_DIG;
               end
            end
         end
         ST_DIG: begin
            kind_in  = DK_DIGIT;
            state_in = ST_WAIT;
         end
         ST_AMOD: begin
            kind_in  = DK_AMOD;
            state_in = ST_WAIT;
         end
         ST_BMOD: begin
            kind_in  = DK_BMOD;
            state_in = ST_WAIT;
         end
         ST_SQ: begin
            val_in   = 32'(mul_p[15:0]);
            state_in = ST_SQMOD;
         end
         ST_SQMOD: begin
            kind_in  = DK_SQMOD;
            state_in = ST_WAIT;
         end
         ST_EUC: begin
            if (r1_ff == 8'd0) begin
               state_in = ST_INV;
            end else begin
               kind_in  = DK_EUCLID;
               state_in = ST_WAIT;
            end
         end
         ST_INV: begin
            // No inverse when the gcd is not one; then the corner entry is zero.
            if (r0_ff != 8'd1)        inv_in = 8'd0;
            else if (t0_ff < 12'sd0)  inv_in = 8'(t0_ff + p_s);
            else if (t0_ff >= p_s)    inv_in = 8'(t0_ff - p_s);
            else                      inv_in = t0_ff[7:0];
            state_in = ST_CMUL;
         end
         ST_CMUL: begin
            val_in   = 32'(mul_p[15:0]);
            state_in = ST_CMOD;
         end
         ST_CMOD: begin
            kind_in  = DK_CMOD;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_done) begin
               case (kind_ff)
                  DK_DIGIT: begin
                     dig_in[dig_idx_ff] = div_rem;
                     val_in             = div_quot;
                     dig_idx_in         = dig_idx_ff + 2'd1;
                     state_in = (dig_idx_ff + 2'd1 == ndig_ff) ? ST_FIELDS : ST_DIG;
                  end
                  DK_AMOD: begin
                     fa_in    = 16'(div_rem) + 16'd1;
                     state_in = ST_BMOD;
                  end
                  DK_BMOD: begin
                     fb_in    = div_rem;
                     state_in = ST_SQ;
                  end
                  DK_SQMOD: begin
                     x_in     = div_rem;
                     r0_in    = p_ff;
                     r1_in    = fa_ff[7:0];
                     t0_in    = 12'sd0;
                     t1_in    = 12'sd1;
                     state_in = ST_EUC;
                  end
                  DK_EUCLID: begin
                     r0_in    = r1_ff;
                     r1_in    = div_rem;
                     t0_in    = t1_ff;
                     t1_in    = 12'(21'(t0_ff) - euc_prod);
                     state_in = ST_EUC;
                  end
                  DK_CMOD: begin
                     fc_in    = 16'(div_rem);
                     state_in = ST_MUL0;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_FIELDS: begin
            case (case_ff)
               hcm_pkg::CASE_F0_DIGITS: begin
                  fa_in = 16'(dig_ff[0]);
                  fb_in = dig_ff[1];
                  fc_in = 16'(dig_ff[2]);
               end
               hcm_pkg::CASE_F0_LOWER: begin
                  fa_in = 16'(dig_ff[0]);
                  fb_in = dig_ff[1];
               end
               hcm_pkg::CASE_F1_MID: begin
                  fb_in = dig_ff[0];
                  fa_in = val_ff[15:0];
               end
               hcm_pkg::CASE_F1_TOP: begin
                  fa_in = 16'(dig_ff[0]);
                  fb_in = dig_ff[1];
                  fc_in = val_ff[15:0];
               end
               default: fa_in = fa_ff;
            endcase
            state_in = ST_MUL0;
         end
         ST_MUL0: begin
            bp_in    = mul_p[15:0];
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            ap_in    = mul_p[23:0];
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            ab_in    = mul_p[23:0];
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (load_row) begin
               row_in = row_ff + 2'd1;
               if (oor_ff || row_ff == 2'd3) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output register: one beat per matrix row.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      if (load_row) begin
         rsp_valid_in = 1'b1;
         if (oor_ff) begin
            rsp_data_in = '0;
            rsp_user_in = 1'b1;
            rsp_last_in = 1'b1;
         end else begin
            rsp_data_in = {6'b0, row_val.col3, row_val.col2, row_val.col1,
                           row_val.col0, row_ff};
            rsp_user_in = 1'b0;
            rsp_last_in = (row_ff == 2'd3);
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prime_ff     <= 8'd2;
         family_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prime_ff     <= prime_in;
         family_ff    <= family_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff        <= k_in;
      p_ff        <= p_in;
      fam_ff      <= fam_in;
      p2_ff       <= p2_in;
      p3_ff       <= p3_in;
      p4_ff       <= p4_in;
      cnt_ff      <= cnt_in;
      base1_ff    <= base1_in;
      base2_ff    <= base2_in;
      case_ff     <= case_in;
      oor_ff      <= oor_in;
      val_ff      <= val_in;
      dig_ff      <= dig_in;
      dig_idx_ff  <= dig_idx_in;
      ndig_ff     <= ndig_in;
      fa_ff       <= fa_in;
      fb_ff       <= fb_in;
      fc_ff       <= fc_in;
      bp_ff       <= bp_in;
      ap_ff       <= ap_in;
      ab_ff       <= ab_in;
      x_ff        <= x_in;
      r0_ff       <= r0_in;
      r1_ff       <= r1_in;
      t0_ff       <= t0_in;
      t1_ff       <= t1_in;
      inv_ff      <= inv_in;
      kind_ff     <= kind_in;
      row_ff      <= row_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign csr_ready  = 1'b1;

   // The divider is never restarted while it is still working.
   a_div_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   // A normal matrix ends on its fourth row.
   a_last_is_row3: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast && !rsp_tuser) |-> (rsp_tdata[1:0] == 2'd3))
      else $error("last beat of a matrix is not row 3");

   // An out-of-range beat is a single all-zero beat.
   a_oor_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tlast && rsp_tdata == '0))
      else $error("out-of-range beat is not a lone zero beat");

   // Euclid remainders shrink on every step.
   a_euclid_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EUC) |-> (r1_ff < r0_ff))
      else $error("Euclid remainder not below divisor");

endmodule

`default_nettype wire
